// ===== rtl/core/idq_pkg.sv =====
// shared types, codes and sizes of the indexed array deque
`timescale 1ns / 1ps

package idq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // request kinds
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd3;

    // result codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_RDW,
        ST_MOVE,
        ST_FIN,
        ST_DONE
    } state_t;

    // one request to the element store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // one finished result
    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [COUNT_W-1:0]       element_count;
        logic [STATUS_W-1:0]      status;
    } result_t;

endpackage

// ===== rtl/core/idq_mem.sv =====
// element store: one write port, one read port with registered read data
`timescale 1ns / 1ps

module idq_mem
    import idq_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] element_store [CAPACITY];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            element_store[req.waddr] <= req.wdata;
        end
    end

    // read port, read data registered
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= element_store[req.raddr];
        end
    end

endmodule

// ===== rtl/core/idq_ctrl.sv =====
// request sequencer: checks, element moves and head/count bookkeeping
`timescale 1ns / 1ps

module idq_ctrl
    import idq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [MODE_W-1:0]  in_mode,
    input  logic [COUNT_W-1:0] in_position,
    input  logic [DATA_W-1:0]  in_data,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res,
    output mem_req_t           mem_req,
    input  logic [DATA_W-1:0]  mem_rdata
);

    state_t state_reg, state_next;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [DATA_W-1:0]   din_reg, din_next;
    logic [ADDR_W-1:0]   slot_reg, slot_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [ADDR_W-1:0]   head_new_reg, head_new_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  count_new_reg, count_new_next;
    logic [ADDR_W-1:0]   src_reg, src_next;
    logic [COUNT_W-1:0]  moves_reg, moves_next;
    logic                up_reg, up_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [DATA_W-1:0]   dout_reg, dout_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                err_reg, err_next;

    logic                accept;
    logic [COUNT_W-1:0]  half;
    logic                front;
    logic [ADDR_W-1:0]   pos_slot;
    logic [ADDR_W-1:0]   cnt_slot;
    logic [STATUS_W-1:0] chk_status;

    assign accept   = in_valid && in_ready;
    assign half     = count_reg >> 1;
    assign front    = in_position < half;
    assign pos_slot = in_position[ADDR_W-1:0];
    assign cnt_slot = count_reg[ADDR_W-1:0];

    // request checks, full and empty ahead of the index check
    always_comb
    begin
        chk_status = STATUS_OK;
        case (in_mode)
            MODE_INSERT:
            begin
                if (count_reg == COUNT_W'(CAPACITY))
                    chk_status = STATUS_FULL;
                else if (in_position > count_reg)
                    chk_status = STATUS_RANGE;
            end
            MODE_REMOVE:
            begin
                if (count_reg == '0)
                    chk_status = STATUS_EMPTY;
                else if (in_position >= count_reg)
                    chk_status = STATUS_RANGE;
            end
            default:
            begin
                if (in_position >= count_reg)
                    chk_status = STATUS_RANGE;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (chk_status != STATUS_OK)
                        state_next = ST_DONE;
                    else if (in_mode == MODE_INSERT)
                        state_next = ST_MOVE;
                    else
                        state_next = ST_RD;
                end
            end
            ST_RD:
                state_next = ST_RDW;
            ST_RDW:
            begin
                if (mode_reg == MODE_REMOVE)
                    state_next = ST_MOVE;
                else
                    state_next = ST_DONE;
            end
            ST_MOVE:
            begin
                if (moves_reg == '0 && !pend_reg)
                    state_next = ST_FIN;
            end
            ST_FIN:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory requests per state
    always_comb
    begin
        mode_next      = mode_reg;
        din_next       = din_reg;
        slot_next      = slot_reg;
        head_next      = head_reg;
        head_new_next  = head_new_reg;
        count_next     = count_reg;
        count_new_next = count_new_reg;
        src_next       = src_reg;
        moves_next     = moves_reg;
        up_next        = up_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        dout_next      = dout_reg;
        status_next    = status_reg;
        err_next       = err_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        mem_req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    mode_next      = in_mode;
                    din_next       = in_data;
                    status_next    = chk_status;
                    err_next       = chk_status != STATUS_OK;
                    dout_next      = '0;
                    pend_next      = 1'b0;
                    slot_next      = head_reg + pos_slot;
                    head_new_next  = head_reg;
                    count_new_next = count_reg;
                    src_next       = head_reg;
                    moves_next     = '0;
                    up_next        = 1'b1;
                    if (in_mode == MODE_INSERT)
                    begin
                        count_new_next = count_reg + COUNT_W'(1);
                        if (front)
                        begin
                            // front part moves down one slot, head follows
                            head_new_next = head_reg - ADDR_W'(1);
                            slot_next     = head_reg - ADDR_W'(1) + pos_slot;
                            src_next      = head_reg;
                            up_next       = 1'b1;
                            moves_next    = in_position;
                        end
                        else
                        begin
                            // back part moves up one slot
                            src_next   = head_reg + cnt_slot - ADDR_W'(1);
                            up_next    = 1'b0;
                            moves_next = count_reg - in_position;
                        end
                    end
                    else if (in_mode == MODE_REMOVE)
                    begin
                        count_new_next = count_reg - COUNT_W'(1);
                        if (front)
                        begin
                            // front part closes the gap, head advances
                            head_new_next = head_reg + ADDR_W'(1);
                            src_next      = head_reg + pos_slot - ADDR_W'(1);
                            up_next       = 1'b0;
                            moves_next    = in_position;
                        end
                        else
                        begin
                            src_next   = head_reg + pos_slot + ADDR_W'(1);
                            up_next    = 1'b1;
                            moves_next = count_reg - COUNT_W'(1) - in_position;
                        end
                    end
                end
            end
            ST_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = slot_reg;
            end
            ST_RDW:
            begin
                dout_next = mem_rdata;
                if (mode_reg == MODE_SET)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = slot_reg;
                    mem_req.wdata = din_reg;
                end
            end
            ST_MOVE:
            begin
                // write back the element read last cycle
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pend_addr_reg;
                    mem_req.wdata = mem_rdata;
                end
                // read the next element to move
                if (moves_reg != '0)
                begin
                    mem_req.re     = 1'b1;
                    mem_req.raddr  = src_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = up_reg ? src_reg - ADDR_W'(1) : src_reg + ADDR_W'(1);
                    src_next       = up_reg ? src_reg + ADDR_W'(1) : src_reg - ADDR_W'(1);
                    moves_next     = moves_reg - COUNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_FIN:
            begin
                if (mode_reg == MODE_INSERT)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = slot_reg;
                    mem_req.wdata = din_reg;
                end
                head_next  = head_new_reg;
                count_next = count_new_reg;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (err_reg)
                    dout_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign res.data_out      = err_reg ? '0 : dout_reg;
    assign res.element_count = count_reg;
    assign res.status        = status_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            moves_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            moves_reg <= moves_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        din_reg       <= din_next;
        slot_reg      <= slot_next;
        head_new_reg  <= head_new_next;
        count_new_reg <= count_new_next;
        src_reg       <= src_next;
        up_reg        <= up_next;
        pend_addr_reg <= pend_addr_next;
        dout_reg      <= dout_next;
        status_reg    <= status_next;
        err_reg       <= err_next;
    end

endmodule

// ===== rtl/core/indexed_array_deque.sv =====
// indexed array deque top level: stream ports, sequencer, store, result register
//
// A deque of up to 64 signed 32-bit elements with access by position.
// Input channel s_axis_*: one beat is one request (get, set, insert at or
// remove at a logical index). Output channel m_axis_*: one beat per request,
// carrying the read or previous value, the element count after the request
// and a status code (ok, index out of range, full, empty).
// Requests are taken one at a time. A get or set passes a read state and a
// read-wait state on its way to the result register. Insert and remove move
// the shorter side of the deque one element per cycle through the store (one
// read port, one write port: read one slot, write it one slot over on the
// next cycle, pipelined), in a move state and then a final state; a remove
// first reads the element it takes out. At most 32 elements move for an
// insert and 31 for a remove. Errors go straight to the result state. The
// next request is taken in the cycle after the result is registered.
// The result sits in an output register; the block takes the next request
// while it waits there, and stalls only when a new result is ready and the
// receiver still holds tready low.
// Reset empties the deque (count and head to zero); the store contents are
// not cleared and need no clearing pass.
`timescale 1ns / 1ps

module indexed_array_deque
    import idq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // mode[1:0], position[8:2], data_in[40:9], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // data_out[31:0], element_count[38:32], status[40:39], zero pad
);

    localparam int IN_BITS  = MODE_W + COUNT_W + DATA_W;
    localparam int OUT_BITS = DATA_W + COUNT_W + STATUS_W;

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    logic              res_valid;
    logic              res_ready;
    result_t           res;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    idq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_mode     (s_axis_tdata[MODE_W-1:0]),
        .in_position (s_axis_tdata[MODE_W+COUNT_W-1:MODE_W]),
        .in_data     (s_axis_tdata[IN_BITS-1:MODE_W+COUNT_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    idq_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // output register loads when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // pack result beat, lowest field first
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(48 - OUT_BITS){1'b0}}, out_reg.status,
                            out_reg.element_count, out_reg.data_out};

endmodule

// ===== tb/indexed_array_deque_checker.sv =====
// reply checker for the indexed array deque: tracks requests, predicts replies, compares fields
`timescale 1ns / 1ps

module indexed_array_deque_checker
    import idq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // mode[1:0], position[8:2], data_in[40:9], zero pad
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // data_out[31:0], element_count[38:32], status[40:39], pad
    output int          mismatch_count,
    output int          replies_pending
);

    // shadow copy of the deque
    logic [DATA_W-1:0]  shadow_mem [CAPACITY];
    logic [ADDR_W-1:0]  shadow_head;
    logic [COUNT_W-1:0] shadow_count;

    // replies still owed by the block, oldest first
    result_t reply_queue [$];

    // physical slot of a logical index
    function automatic logic [ADDR_W-1:0] slot_of_index(int idx);
        logic [ADDR_W-1:0] slot;
        slot = ADDR_W'((int'(shadow_head) + idx) % CAPACITY);
        return slot;
    endfunction

    // apply one request to the shadow deque and return the reply it should give
    function automatic result_t deque_apply(logic [MODE_W-1:0] mode, int pos,
                                            logic [DATA_W-1:0] din);
        result_t reply;
        int      level;
        int      k;
        reply = '0;
        reply.status = STATUS_OK;
        level = int'(shadow_count);
        case (mode)
            MODE_GET, MODE_SET:
            begin
                if (pos >= level)
                    reply.status = STATUS_RANGE;
                else
                begin
                    reply.data_out = shadow_mem[slot_of_index(pos)];
                    if (mode == MODE_SET)
                        shadow_mem[slot_of_index(pos)] = din;
                end
            end
            MODE_INSERT:
            begin
                // full is checked ahead of the index
                if (level >= CAPACITY)
                    reply.status = STATUS_FULL;
                else if (pos > level)
                    reply.status = STATUS_RANGE;
                else
                begin
                    if (pos < level / 2)
                    begin
                        // front part slides toward the new head
                        shadow_head = ADDR_W'((int'(shadow_head) + CAPACITY - 1) % CAPACITY);
                        for (k = 0; k < pos; k++)
                            shadow_mem[slot_of_index(k)] = shadow_mem[slot_of_index(k + 1)];
                    end
                    else
                    begin
                        // back part slides toward the tail
                        for (k = level; k > pos; k--)
                            shadow_mem[slot_of_index(k)] = shadow_mem[slot_of_index(k - 1)];
                    end
                    shadow_mem[slot_of_index(pos)] = din;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            default:
            begin
                // remove: empty is checked ahead of the index
                if (level == 0)
                    reply.status = STATUS_EMPTY;
                else if (pos >= level)
                    reply.status = STATUS_RANGE;
                else
                begin
                    reply.data_out = shadow_mem[slot_of_index(pos)];
                    if (pos < level / 2)
                    begin
                        // close the gap from the front, head advances
                        for (k = pos; k >= 1; k--)
                            shadow_mem[slot_of_index(k)] = shadow_mem[slot_of_index(k - 1)];
                        shadow_head = ADDR_W'((int'(shadow_head) + 1) % CAPACITY);
                    end
                    else
                    begin
                        // close the gap from the back
                        for (k = pos; k + 1 < level; k++)
                            shadow_mem[slot_of_index(k)] = shadow_mem[slot_of_index(k + 1)];
                    end
                    shadow_count = shadow_count - 1'b1;
                end
            end
        endcase
        reply.element_count = shadow_count;
        return reply;
    endfunction

    // watch both channels, predict on request beats, compare on reply beats
    always @(posedge clk or negedge rst_n)
    begin : watch_beats
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            shadow_head    = '0;
            shadow_count   = '0;
            mismatch_count = 0;
            reply_queue.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                reply_queue.push_back(deque_apply(s_axis_tdata[1:0], int'(s_axis_tdata[8:2]),
                                                  s_axis_tdata[40:9]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.data_out      = m_axis_tdata[31:0];
                got.element_count = m_axis_tdata[38:32];
                got.status        = m_axis_tdata[40:39];
                if (reply_queue.size() == 0)
                begin
                    $error("reply beat with no request outstanding: data_out %0d count %0d status %0d",
                           got.data_out, got.element_count, got.status);
                    mismatch_count++;
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (got.data_out !== want.data_out)
                    begin
                        $error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
                        mismatch_count++;
                    end
                    if (got.element_count !== want.element_count)
                    begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, got.element_count);
                        mismatch_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatch_count++;
                    end
                end
            end
        end
        replies_pending = reply_queue.size();
    end

endmodule

// ===== tb/indexed_array_deque_tb.sv =====
// testbench top for the indexed array deque: clock, reset, request stimulus, reply backpressure
`timescale 1ns / 1ps

module indexed_array_deque_tb;
    import idq_pkg::*;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;     // mode[1:0], position[8:2], data_in[40:9], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // data_out[31:0], element_count[38:32], status[40:39], pad

    int   mismatch_count;
    int   replies_pending;

    // idling knobs, in percent: of requests with an idle gap ahead, and of receiver cycles stalled
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;

    // long receiver hold-off
    logic long_hold_armed = 1'b0;
    logic long_hold_taken = 1'b0;
    int   hold_left       = 0;

    // element count tracked only to steer positions, plus fill or drain direction
    int   fill_level = 0;
    logic grow_phase = 1'b1;

    always #2 clk = ~clk;

    indexed_array_deque uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    indexed_array_deque_checker deque_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatch_count  (mismatch_count),
        .replies_pending (replies_pending)
    );

    // reply side: random stalls, one long hold-off when armed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready   <= 1'b0;
            hold_left       <= 0;
            long_hold_taken <= 1'b0;
        end
        else if (long_hold_armed && !long_hold_taken)
        begin
            m_axis_tready   <= 1'b0;
            hold_left       <= 300;
            long_hold_taken <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // offer one request beat, maybe after an idle gap, and wait until it is taken
    task automatic send_request(logic [MODE_W-1:0] mode, int pos, logic [DATA_W-1:0] din);
        logic [6:0] pos_bits;
        pos_bits = 7'(pos);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, din, pos_bits, mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (mode == MODE_INSERT && fill_level < CAPACITY && pos <= fill_level)
            fill_level++;
        else if (mode == MODE_REMOVE && fill_level > 0 && pos < fill_level)
            fill_level--;
    endtask

    // random request, steered to sweep the deque between empty and full
    task automatic send_random_request();
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] din;
        int                pick;
        int                pos;
        int                last_ok;
        // linger at the extremes so full and empty errors show up
        if (fill_level == CAPACITY && $urandom_range(3) == 0)
            grow_phase = 1'b0;
        else if (fill_level == 0 && $urandom_range(3) == 0)
            grow_phase = 1'b1;
        pick = $urandom_range(99);
        if (pick < 50)
            mode = grow_phase ? MODE_INSERT : MODE_REMOVE;
        else if (pick < 65)
            mode = grow_phase ? MODE_REMOVE : MODE_INSERT;
        else if (pick < 82)
            mode = MODE_GET;
        else
            mode = MODE_SET;

        // mostly legal positions, weighted toward the ends and the midpoint
        last_ok = (mode == MODE_INSERT) ? fill_level : fill_level - 1;
        pick = $urandom_range(99);
        if (pick < 12 || last_ok < 0)
            pos = $urandom_range(127);
        else if (pick < 30)
        begin
            case ($urandom_range(3))
                0:       pos = 0;
                1:       pos = last_ok;
                2:       pos = fill_level / 2;
                default: pos = (fill_level / 2 > 0) ? fill_level / 2 - 1 : 0;
            endcase
        end
        else
            pos = $urandom_range(last_ok, 0);

        if ($urandom_range(9) == 0)
        begin
            case ($urandom_range(3))
                0:       din = 32'h0000_0000;
                1:       din = 32'h7FFF_FFFF;
                2:       din = 32'h8000_0000;
                default: din = 32'hFFFF_FFFF;
            endcase
        end
        else
            din = $urandom;
        send_request(mode, pos, din);
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int phase;
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // errors on an empty deque
        send_request(MODE_GET,    0,   32'h0);
        send_request(MODE_REMOVE, 0,   32'h0);
        send_request(MODE_REMOVE, 127, 32'h0);
        send_request(MODE_INSERT, 1,   32'h1);
        // build up: append, front insert wrapping the head below slot zero, both halves
        send_request(MODE_INSERT, 0,   32'h7FFF_FFFF);
        send_request(MODE_INSERT, 1,   32'h8000_0000);
        send_request(MODE_INSERT, 0,   32'hFFFF_FFFF);
        send_request(MODE_INSERT, 2,   32'h0000_0000);
        send_request(MODE_INSERT, 4,   32'h5A5A_5A5A);
        send_request(MODE_INSERT, 1,   32'hA5A5_A5A5);
        // reads and writes in and out of range
        send_request(MODE_GET,    0,   32'h0);
        send_request(MODE_GET,    5,   32'h0);
        send_request(MODE_GET,    6,   32'h0);
        send_request(MODE_GET,    64,  32'h0);
        send_request(MODE_GET,    127, 32'hFFFF_FFFF);
        send_request(MODE_SET,    3,   32'h1234_5678);
        send_request(MODE_SET,    6,   32'hDEAD_BEEF);
        send_request(MODE_SET,    0,   32'h8000_0000);
        // removes from the front half and the back, then bad indexes
        send_request(MODE_REMOVE, 1,   32'h0);
        send_request(MODE_REMOVE, 4,   32'h0);
        send_request(MODE_REMOVE, 5,   32'h0);
        send_request(MODE_REMOVE, 127, 32'h0);
        send_request(MODE_INSERT, 64,  32'h0);
        send_request(MODE_INSERT, 127, 32'h0);

        // random traffic under each idling mix
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 45; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 45; end
                default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
            endcase
            for (n = 0; n < 210; n++)
            begin
                if (phase == 0 && n == 40)
                    long_hold_armed <= 1'b1;
                send_random_request();
            end
        end
        s_axis_tvalid <= 1'b0;
        rx_stall_pct = 0;

        // drain outstanding replies, then let the block settle
        while (replies_pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && replies_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
